// File: src/kpms_pkg.sv
// ----------------------------------------------------------------------------
// kpms_pkg
// Shared types, constants and helpers for the multi-stream KISS generator.
// ----------------------------------------------------------------------------
package kpms_pkg;

  localparam int STREAMS_DEF = 32;
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 8;
  localparam int OP_W        = 2;
  localparam int WORD_W      = 4 * DATA_W;

  localparam logic [OP_W-1:0] OP_DRAW     = 2'd0;
  localparam logic [OP_W-1:0] OP_SEED_ONE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEED_ALL = 2'd2;

  localparam logic [DATA_W-1:0] LCG_INIT   = 32'd123456789;
  localparam logic [DATA_W-1:0] XOR_INIT   = 32'd362436000;
  localparam logic [DATA_W-1:0] MWC_INIT   = 32'd521288629;
  localparam logic [DATA_W-1:0] CARRY_INIT = 32'd7654321;
  localparam logic [DATA_W-1:0] LCG_MUL    = 32'd69069;
  localparam logic [DATA_W-1:0] LCG_ADD    = 32'd12345;
  localparam logic [DATA_W-1:0] MWC_MUL    = 32'd698769069;
  localparam int XS_SHL_A = 13;
  localparam int XS_SHR   = 17;
  localparam int XS_SHL_B = 5;

  typedef enum logic [1:0] {
    K_DRAW,
    K_SEED_ONE,
    K_SEED_ALL,
    K_NOP
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [INDEX_W-1:0]  idx;
    logic [DATA_W-1:0]   seed;
    logic                status;
  } cmd_t;

  typedef struct packed {
    logic [DATA_W-1:0] lcg;
    logic [DATA_W-1:0] xs;
    logic [DATA_W-1:0] mwc;
    logic [DATA_W-1:0] carry;
  } stream_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_DONE
  } back_st_e;

  function automatic stream_t seed_words(input logic [DATA_W-1:0] seed);
    stream_t w;
    if (seed == '0) begin
      w.lcg   = LCG_INIT;
      w.xs    = XOR_INIT;
      w.mwc   = MWC_INIT;
      w.carry = CARRY_INIT;
    end else begin
      w.lcg   = seed;
      w.xs    = seed;
      w.mwc   = seed;
      w.carry = seed;
    end
    return w;
  endfunction

endpackage

// File: src/kpms_if.sv
// ----------------------------------------------------------------------------
// kpms_if
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface kpms_req_if import kpms_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [OP_W-1:0]     opcode;
  logic [INDEX_W-1:0]  stream_index;
  logic [DATA_W-1:0]   seed_value;

  modport source (output valid, output opcode, output stream_index, output seed_value,
                  input ready);
  modport sink   (input valid, input opcode, input stream_index, input seed_value,
                  output ready);
endinterface

interface kpms_rsp_if import kpms_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] random_value;
  logic              status;

  modport source (output valid, output random_value, output status, input ready);
  modport sink   (input valid, input random_value, input status, output ready);
endinterface

// File: src/kpms_ram.sv
// ----------------------------------------------------------------------------
// kpms_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module kpms_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/kpms_front.sv
// ----------------------------------------------------------------------------
// kpms_front
// Request intake: decode opcode, range-check the stream index, build command.
// ----------------------------------------------------------------------------
module kpms_front import kpms_pkg::*; #(
  parameter int STREAMS = STREAMS_DEF
) (
  kpms_req_if.sink req_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  localparam logic [INDEX_W:0] STREAMS_L = (INDEX_W+1)'(STREAMS);

  logic in_range;

  assign in_range    = {1'b0, req_i.stream_index} < STREAMS_L;
  assign req_i.ready = !full_i;
  assign push_o      = req_i.valid && !full_i;

  always_comb begin
    cmd_o.seed   = req_i.seed_value;
    cmd_o.idx    = req_i.stream_index;
    cmd_o.status = 1'b0;
    cmd_o.kind   = K_NOP;
    case (req_i.opcode)
      OP_DRAW: begin
        cmd_o.kind = K_DRAW;
        if (!in_range) begin
          cmd_o.idx = '0;
        end
      end
      OP_SEED_ONE: begin
        if (in_range) begin
          cmd_o.kind = K_SEED_ONE;
        end else begin
          cmd_o.status = 1'b1;
        end
      end
      OP_SEED_ALL: cmd_o.kind = K_SEED_ALL;
      default:     cmd_o.kind = K_NOP;
    endcase
  end

endmodule

// File: src/kpms_queue.sv
// ----------------------------------------------------------------------------
// kpms_queue
// Two-entry command queue between intake and execution.
// ----------------------------------------------------------------------------
module kpms_queue import kpms_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  output cmd_t cmd_o,
  input  logic pop_i
);

  cmd_t       entry_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] count_q, count_d;

  assign full_o  = count_q == 2'd2;
  assign valid_o = count_q != 2'd0;
  assign cmd_o   = entry_q[rptr_q];

  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d  = !wptr_q;
      count_d = count_d + 2'd1;
    end
    if (pop_i) begin
      rptr_d  = !rptr_q;
      count_d = count_d - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wptr_q] <= cmd_i;
    end
  end

endmodule

// File: src/kpms_back.sv
// ----------------------------------------------------------------------------
// kpms_back
// Command execution: stream state RAM, KISS update and response register.
// ----------------------------------------------------------------------------
module kpms_back import kpms_pkg::*; #(
  parameter int STREAMS = STREAMS_DEF,
  localparam int IDX_W  = (STREAMS > 1) ? $clog2(STREAMS) : 1
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_valid_i,
  input  cmd_t        q_cmd_i,
  output logic        q_pop_o,
  kpms_rsp_if.source  rsp_o
);

  back_st_e          state_q, state_d;
  cmd_t              cmd_q;
  logic [STREAMS-1:0] valid_q;
  logic [DATA_W-1:0] base_q;
  logic              hit_q;

  logic [DATA_W-1:0]   lcg_prod_q;
  logic [2*DATA_W-1:0] mwc_prod_q;
  logic [DATA_W-1:0]   xs_q;
  logic [DATA_W-1:0]   carry_q;

  logic              out_valid_q;
  logic [DATA_W-1:0] out_value_q;
  logic              out_status_q;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [IDX_W-1:0]  ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  stream_t             word;
  logic [DATA_W-1:0]   y1, y2, y3;
  logic [2*DATA_W-1:0] t_sum;
  logic [DATA_W-1:0]   lcg_new;
  stream_t             draw_word;
  logic [DATA_W-1:0]   draw_value;
  logic                out_free;
  logic                done_fire;

  kpms_ram #(.WIDTH(WORD_W), .DEPTH(STREAMS)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign word = hit_q ? stream_t'(ram_rdata) : seed_words(base_q);
  assign y1   = word.xs ^ (word.xs << XS_SHL_A);
  assign y2   = y1 ^ (y1 >> XS_SHR);
  assign y3   = y2 ^ (y2 << XS_SHL_B);

  assign t_sum           = mwc_prod_q + {{DATA_W{1'b0}}, carry_q};
  assign lcg_new         = lcg_prod_q + LCG_ADD;
  assign draw_word.lcg   = lcg_new;
  assign draw_word.xs    = xs_q;
  assign draw_word.mwc   = t_sum[DATA_W-1:0];
  assign draw_word.carry = t_sum[2*DATA_W-1:DATA_W];
  assign draw_value      = lcg_new + xs_q + t_sum[DATA_W-1:0];

  assign out_free  = !out_valid_q || rsp_o.ready;
  assign done_fire = (state_q == ST_DONE) && out_free;
  assign ram_raddr = q_cmd_i.idx[IDX_W-1:0];
  assign ram_waddr = cmd_q.idx[IDX_W-1:0];

  always_comb begin
    state_d   = state_q;
    q_pop_o   = 1'b0;
    ram_re    = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = WORD_W'(draw_word);
    case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          ram_re  = q_cmd_i.kind == K_DRAW;
          state_d = (q_cmd_i.kind == K_DRAW) ? ST_FETCH : ST_DONE;
        end
      end
      ST_FETCH: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
          if (cmd_q.kind == K_DRAW) begin
            ram_we = 1'b1;
          end else if (cmd_q.kind == K_SEED_ONE) begin
            ram_we    = 1'b1;
            ram_wdata = WORD_W'(seed_words(cmd_q.seed));
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      base_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_fire) begin
        out_valid_q <= 1'b1;
        if (cmd_q.kind == K_SEED_ALL) begin
          valid_q <= '0;
          base_q  <= cmd_q.seed;
        end else if (ram_we) begin
          valid_q[ram_waddr] <= 1'b1;
        end
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cmd_q <= q_cmd_i;
      hit_q <= valid_q[ram_raddr];
    end
    if (state_q == ST_FETCH) begin
      lcg_prod_q <= DATA_W'(word.lcg * LCG_MUL);
      mwc_prod_q <= {{DATA_W{1'b0}}, word.mwc} * {{DATA_W{1'b0}}, MWC_MUL};
      xs_q       <= y3;
      carry_q    <= word.carry;
    end
    if (done_fire) begin
      out_value_q  <= (cmd_q.kind == K_DRAW) ? draw_value : '0;
      out_status_q <= cmd_q.status;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.random_value = out_value_q;
  assign rsp_o.status       = out_status_q;

  a_pop_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop_o |-> state_q == ST_IDLE)
    else $error("queue popped while busy");

  a_we_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> done_fire)
    else $error("state RAM written outside completion");

  a_seed_all_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && cmd_q.kind == K_SEED_ALL) |=> valid_q == '0)
    else $error("seed-all left stream entries marked written");

  a_status_nop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_fire && cmd_q.status) |-> cmd_q.kind == K_NOP)
    else $error("error status on an executed command");

endmodule

// File: src/kiss_prng_multi_stream_core.sv
// ----------------------------------------------------------------------------
// kiss_prng_multi_stream_core
// Multi-stream KISS generator: intake, command queue and execution unit.
//
//   channel  dir  fields                                  handshake
//   req_i    in   opcode, stream_index, seed_value        valid/ready
//   rsp_o    out  random_value, status                    valid/ready
//
// A draw passes through the execution unit in order (pop, RAM read and multiply,
// update and write-back); seeds go from pop straight to update. The sequencer
// takes one command at a time, and update waits while the response is stalled.
// Reset clears per-stream written bits; unwritten streams read as words from
// the last common seed (defaults after reset), so there is no clearing pass.
// Seeding all streams clears those bits and latches the seed.
// A two-entry queue absorbs two requests while the response is stalled.
// ----------------------------------------------------------------------------
module kiss_prng_multi_stream_core import kpms_pkg::*; #(
  parameter int STREAMS = STREAMS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  kpms_req_if.sink    req_i,
  kpms_rsp_if.source  rsp_o
);

  logic push;
  logic full;
  cmd_t push_cmd;
  logic q_valid;
  cmd_t q_cmd;
  logic q_pop;

  kpms_front #(.STREAMS(STREAMS)) u_front (
    .req_i  (req_i),
    .full_i (full),
    .push_o (push),
    .cmd_o  (push_cmd)
  );

  kpms_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .cmd_o   (q_cmd),
    .pop_i   (q_pop)
  );

  kpms_back #(.STREAMS(STREAMS)) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_cmd_i   (q_cmd),
    .q_pop_o   (q_pop),
    .rsp_o     (rsp_o)
  );

endmodule
